// ----- rtl/frv_pkg.sv -----
package frv_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned HOP_W     = 13;
  localparam int unsigned SQ_W      = 31;
  localparam int unsigned SUM_W     = 43;
  localparam int unsigned QUO_W     = 38;
  localparam int unsigned ROOT_W    = QUO_W / 2;
  localparam int unsigned REM_W     = ROOT_W + 3;
  localparam int unsigned STEP_W    = 6;

  localparam logic [HOP_W-1:0]  HOP_MIN   = HOP_W'(64);
  localparam logic [HOP_W-1:0]  HOP_MAX   = HOP_W'(4096);
  localparam logic [HOP_W-1:0]  HOP_RESET = HOP_W'(512);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_W - 1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clip_last;
  } in_beat_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               first_frame;
  } out_beat_t;

  typedef struct packed {
    logic load_sample;
    logic square;
    logic accum;
    logic div_step;
    logic root_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic started;
    logic frame_done;
    logic out_free;
  } dp_sts_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SQUARE = 6'b000010,
    ST_ACCUM  = 6'b000100,
    ST_DIVIDE = 6'b001000,
    ST_ROOT   = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

endpackage

// ----- rtl/frv_ctrl.sv -----
module frv_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  frv_pkg::dp_sts_t sts,
  output frv_pkg::dp_cmd_t cmd
);
  import frv_pkg::*;

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_sample = 1'b1;
          state_nxt       = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accum = 1'b1;
        step_nxt  = '0;
        if (!sts.started) begin
          state_nxt = ST_EMIT;
        end else if (sts.frame_done) begin
          state_nxt = ST_DIVIDE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == DIV_LAST) begin
          step_nxt  = '0;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        step_nxt      = step_r + STEP_W'(1);
        if (step_r == ROOT_LAST) begin
          step_nxt  = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ----- rtl/frv_dp.sv -----
module frv_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  frv_pkg::in_beat_t              in_beat,
  input  logic [frv_pkg::HOP_W-1:0]      hop,
  input  frv_pkg::dp_cmd_t               cmd,
  output frv_pkg::dp_sts_t               sts,
  output logic                           out_valid,
  input  logic                           out_stall,
  output frv_pkg::out_beat_t             out_beat
);
  import frv_pkg::*;

  logic [SAMPLE_W-1:0] mag_r;
  logic                last_r;
  logic [SQ_W-1:0]     sq_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [HOP_W-1:0]    count_r, count_nxt;
  logic                started_r, started_nxt;
  logic                pend_first_r;
  logic [SUM_W-1:0]    num_r;
  logic [HOP_W-1:0]    drem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [REM_W-1:0]    rrem_r;
  logic                out_valid_r;
  out_beat_t           out_beat_r;

  logic [SUM_W-1:0]    sum_add;
  logic [HOP_W:0]      count_inc;
  logic                frame_done;
  logic [HOP_W-1:0]    drem_sh;
  logic                div_ge;
  logic [REM_W-1:0]    rrem_sh;
  logic [REM_W-1:0]    trial;
  logic                root_ge;
  logic [LEVEL_W-1:0]  root_level;
  logic                out_free;

  assign sum_add    = sum_r + SUM_W'(sq_r);
  assign count_inc  = {1'b0, count_r} + (HOP_W+1)'(1);
  assign frame_done = started_r && (count_inc >= {1'b0, hop});

  assign drem_sh = {drem_r[HOP_W-2:0], num_r[SUM_W-1]};
  assign div_ge  = drem_sh >= hop;

  assign rrem_sh = {rrem_r[REM_W-3:0], num_r[QUO_W-1:QUO_W-2]};
  assign trial   = REM_W'({root_r, 2'b01});
  assign root_ge = rrem_sh >= trial;

  assign root_level = (root_r[ROOT_W-1:LEVEL_W] != '0) ? '1 : root_r[LEVEL_W-1:0];

  assign out_free = !out_valid_r || !out_stall;

  assign sts.started    = started_r;
  assign sts.frame_done = frame_done;
  assign sts.out_free   = out_free;

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // frame accumulation
  always_comb begin
    sum_nxt     = sum_r;
    count_nxt   = count_r;
    started_nxt = started_r;
    if (cmd.accum) begin
      if (!started_r) begin
        sum_nxt     = SUM_W'(sq_r);
        count_nxt   = HOP_W'(1);
        started_nxt = 1'b1;
      end else if (frame_done) begin
        sum_nxt   = '0;
        count_nxt = '0;
      end else begin
        sum_nxt   = sum_add;
        count_nxt = count_inc[HOP_W-1:0];
      end
      if (last_r) begin
        sum_nxt     = '0;
        count_nxt   = '0;
        started_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      count_r     <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r     <= sum_nxt;
      count_r   <= count_nxt;
      started_r <= started_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      mag_r  <= in_beat.sample[SAMPLE_W-1] ? (~in_beat.sample + SAMPLE_W'(1))
                                           : in_beat.sample;
      last_r <= in_beat.clip_last;
    end
    if (cmd.square) begin
      sq_r <= SQ_W'(mag_r * mag_r);
    end
    if (cmd.accum) begin
      pend_first_r <= !started_r;
      num_r        <= sum_add;
      drem_r       <= '0;
      root_r       <= '0;
      rrem_r       <= '0;
    end
    // restoring divide, one quotient bit per cycle
    if (cmd.div_step) begin
      drem_r <= div_ge ? (drem_sh - hop) : drem_sh;
      num_r  <= {num_r[SUM_W-2:0], div_ge};
    end
    // digit-by-digit square root, two radicand bits per cycle
    if (cmd.root_step) begin
      rrem_r <= root_ge ? (rrem_sh - trial) : rrem_sh;
      root_r <= {root_r[ROOT_W-2:0], root_ge};
      num_r  <= {num_r[SUM_W-3:0], 2'b00};
    end
    if (cmd.load_out) begin
      out_beat_r.level       <= pend_first_r ? mag_r : root_level;
      out_beat_r.first_frame <= pend_first_r;
    end
  end

endmodule

// ----- rtl/frame_rms_volume.sv -----
// a sample beat goes through capture, square and accumulate; in_stall is high between beats
// the first sample of a clip puts its magnitude on out as a first_frame beat after the emit
// step, which holds the input until the output is free
// a completed frame then runs the 43-step divider, the 19-step square root and one output
// load, which also waits for the output to be free
// synchronous active-low reset clears the accumulator, the clip state and the output
// valid, and sets hop_length to 512
module frame_rms_volume (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  frv_pkg::in_beat_t         in_beat,
  output logic                      out_valid,
  input  logic                      out_stall,
  output frv_pkg::out_beat_t        out_beat,
  input  logic                      cfg_we,
  input  logic [frv_pkg::HOP_W-1:0] cfg_wdata
);
  import frv_pkg::*;

  logic [HOP_W-1:0] hop_r;
  logic [HOP_W-1:0] hop_eff;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hop_r <= HOP_RESET;
    end else if (cfg_we) begin
      hop_r <= cfg_wdata;
    end
  end

  always_comb begin
    priority if (hop_r < HOP_MIN) begin
      hop_eff = HOP_MIN;
    end else if (hop_r > HOP_MAX) begin
      hop_eff = HOP_MAX;
    end else begin
      hop_eff = hop_r;
    end
  end

  frv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  frv_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_beat),
    .hop       (hop_eff),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after a beat");

  a_out_only_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in flight");

  a_first_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.first_frame) |-> (out_beat.level <= 16'h8000))
    else $error("frame zero level out of sample range");

  a_hop_range: assert property (@(posedge clk) disable iff (!rst_n)
    (hop_eff >= HOP_MIN) && (hop_eff <= HOP_MAX))
    else $error("effective hop out of range");

endmodule
